// ===== src/h2d_pkg.sv =====
// Package with types, constants and helpers shared by the HTTP/2 deframer files.
package h2d_pkg;

	localparam logic [2:0] KIND_PREFACE_OK  = 3'd0;
	localparam logic [2:0] KIND_PREFACE_BAD = 3'd1;
	localparam logic [2:0] KIND_HEADER      = 3'd2;
	localparam logic [2:0] KIND_SETTING     = 3'd3;
	localparam logic [2:0] KIND_PRIORITY    = 3'd4;
	localparam logic [2:0] KIND_BLOCK       = 3'd5;
	localparam logic [2:0] KIND_END         = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PROTO = 2'd1;
	localparam logic [1:0] ST_SIZE  = 2'd2;

	localparam logic [7:0] T_HEADERS      = 8'd1;
	localparam logic [7:0] T_PRIORITY     = 8'd2;
	localparam logic [7:0] T_SETTINGS     = 8'd4;
	localparam logic [7:0] T_CONTINUATION = 8'd9;

	localparam int F_ACK_BIT      = 0;
	localparam int F_PADDED_BIT   = 3;
	localparam int F_PRIORITY_BIT = 5;

	localparam int PREFACE_LEN = 24;
	localparam int HEADER_LEN  = 9;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_id;
		logic [23:0] frame_length;
		logic [15:0] word_a;
		logic [31:0] word_b;
		logic        exclusive;
		logic [1:0]  status;
		logic        last;
	} result_t;

	function automatic logic [7:0] preface_byte(input logic [4:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0: b = 8'h50;
			5'd1: b = 8'h52;
			5'd2: b = 8'h49;
			5'd3: b = 8'h20;
			5'd4: b = 8'h2a;
			5'd5: b = 8'h20;
			5'd6: b = 8'h48;
			5'd7: b = 8'h54;
			5'd8: b = 8'h54;
			5'd9: b = 8'h50;
			5'd10: b = 8'h2f;
			5'd11: b = 8'h32;
			5'd12: b = 8'h2e;
			5'd13: b = 8'h30;
			5'd14: b = 8'h0d;
			5'd15: b = 8'h0a;
			5'd16: b = 8'h0d;
			5'd17: b = 8'h0a;
			5'd18: b = 8'h53;
			5'd19: b = 8'h4d;
			5'd20: b = 8'h0d;
			5'd21: b = 8'h0a;
			5'd22: b = 8'h0d;
			5'd23: b = 8'h0a;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== src/h2d_if.sv =====
// Valid/ready channel interfaces for bytes, results and configuration.
interface h2d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface h2d_result_if;
	import h2d_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface h2d_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/http2_frame_deframer.sv =====
// Top level of the HTTP/2 frame deframer.
// The block takes one received byte per request on the input channel and
// gives result requests on the output channel: preface status, frame header,
// setting pairs, priority fields, header block bytes and a frame end with
// status. One byte causes at most two results; the last one has last set.
// The configuration channel writes preface_required; it is sampled by the
// first byte after reset.
// Each byte is registered, decoded combinationally and its results land in a
// four-entry queue, so a result passes the input register and then the queue
// before it appears. A byte can be taken every cycle while the queue, counting the
// results of the byte in the input register and a result leaving in the same
// cycle, keeps two free entries; a byte that gives two results takes two
// queue entries.
// At reset all parser state clears and the queue empties.
// When the receiver stalls, the queue fills and input ready drops; no result
// is lost.
module http2_frame_deframer (
	input  logic          clk,
	input  logic          arst_n,
	h2d_byte_if.sink      in,
	h2d_cfg_if.sink       cfg,
	h2d_result_if.source  out
);
	import h2d_pkg::*;

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_PREFACE = 3'd1;
	localparam logic [2:0] PH_HEADER  = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_HALT    = 3'd4;

	logic        pref_req_q;
	logic        v_s1;
	logic [7:0]  b_s1;
	logic        room;
	logic        push0, push1;
	result_t     r0, r1;

	logic [2:0]  phase_q;
	logic [4:0]  pidx_q;
	logic [3:0]  hcnt_q;
	logic [23:0] len_q;
	logic [7:0]  type_q;
	logic [7:0]  flags_q;
	logic [30:0] strm_q;
	logic [23:0] left_q;
	logic [7:0]  pad_q;
	logic [2:0]  gcnt_q;
	logic [47:0] gsh_q;
	logic [1:0]  fst_q;

	logic [2:0]  phase_d;
	logic [4:0]  pidx_d;
	logic [3:0]  hcnt_d;
	logic [23:0] len_d;
	logic [7:0]  type_d;
	logic [7:0]  flags_d;
	logic [30:0] strm_d;
	logic [23:0] left_d;
	logic [7:0]  pad_d;
	logic [2:0]  gcnt_d;
	logic [47:0] gsh_d;
	logic [1:0]  fst_d;

	assign in.ready = room;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_req_q <= 1'b1;
			v_s1 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				pref_req_q <= cfg.data;
			end
			v_s1 <= in.valid && in.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			b_s1 <= in.rx_byte;
		end
	end

	// A length is a multiple of six when it is even and its base-4 digit sum
	// is a multiple of three.
	function automatic logic len_mult6(input logic [23:0] l);
		logic [5:0] s;
		logic [3:0] t;
		s = '0;
		for (int i = 0; i < 12; i++) begin
			s = s + {4'd0, l[2*i +: 2]};
		end
		t = {2'd0, s[1:0]} + {2'd0, s[3:2]} + {2'd0, s[5:4]};
		return !l[0] && (t inside {4'd0, 4'd3, 4'd6, 4'd9});
	endfunction

	function automatic logic [1:0] checks(input logic [7:0] t, input logic [7:0] f,
		input logic [30:0] s, input logic [23:0] l);
		logic [1:0] st;
		st = ST_OK;
		if (t == T_SETTINGS) begin
			if (s != 31'd0) st = ST_PROTO;
			else if (f[F_ACK_BIT]) st = (l != 24'd0) ? ST_SIZE : ST_OK;
			else if (!len_mult6(l)) st = ST_SIZE;
		end else if (t == T_PRIORITY) begin
			if (s == 31'd0) st = ST_PROTO;
			else if (l != 24'd5) st = ST_SIZE;
		end else if (t == T_HEADERS) begin
			if (f[F_PADDED_BIT]) begin
				if (l == 24'd0) st = ST_PROTO;
			end else if (f[F_PRIORITY_BIT] && l < 24'd5) begin
				st = ST_SIZE;
			end
		end
		return st;
	endfunction

	function automatic result_t mk(input logic [2:0] k, input logic [7:0] t,
		input logic [7:0] f, input logic [30:0] s, input logic [23:0] l,
		input logic [15:0] a, input logic [31:0] bw, input logic ex, input logic [1:0] st);
		result_t r;
		logic ctx;
		ctx = k >= KIND_HEADER;
		r.kind = k;
		r.frame_type = ctx ? t : 8'd0;
		r.frame_flags = ctx ? f : 8'd0;
		r.stream_id = ctx ? s : 31'd0;
		r.frame_length = ctx ? l : 24'd0;
		r.word_a = a;
		r.word_b = bw;
		r.exclusive = ex;
		r.status = st;
		r.last = 1'b0;
		return r;
	endfunction

	always_comb begin
		logic [2:0]  ph;
		logic        emit_a, emit_b;
		result_t     ra, rb;
		logic [47:0] sh;
		logic        first;
		logic [23:0] rest;
		ph = phase_q;
		phase_d = phase_q;
		pidx_d = pidx_q;
		hcnt_d = hcnt_q;
		len_d = len_q;
		type_d = type_q;
		flags_d = flags_q;
		strm_d = strm_q;
		left_d = left_q;
		pad_d = pad_q;
		gcnt_d = gcnt_q;
		gsh_d = gsh_q;
		fst_d = fst_q;
		emit_a = 1'b0;
		emit_b = 1'b0;
		ra = '0;
		rb = '0;
		sh = {gsh_q[39:0], b_s1};
		first = left_q == len_q;
		rest = len_q - 24'd1;
		if (ph == PH_START) begin
			ph = pref_req_q ? PH_PREFACE : PH_HEADER;
		end
		case (ph)
			PH_PREFACE: begin
				if (b_s1 != preface_byte(pidx_q)) begin
					emit_a = 1'b1;
					ra = mk(KIND_PREFACE_BAD, 8'd0, 8'd0, 31'd0, 24'd0, 16'd0, 32'd0,
						1'b0, ST_OK);
					phase_d = PH_HALT;
				end else begin
					pidx_d = pidx_q + 5'd1;
					phase_d = PH_PREFACE;
					if (pidx_q == 5'(PREFACE_LEN - 1)) begin
						emit_a = 1'b1;
						ra = mk(KIND_PREFACE_OK, 8'd0, 8'd0, 31'd0, 24'd0, 16'd0,
							32'd0, 1'b0, ST_OK);
						phase_d = PH_HEADER;
						hcnt_d = 4'd0;
					end
				end
			end
			PH_HEADER: begin
				phase_d = PH_HEADER;
				if (hcnt_q == 4'd0) begin
					len_d = {16'd0, b_s1};
					strm_d = '0;
				end else if (hcnt_q < 4'd3) begin
					len_d = {len_q[15:0], b_s1};
				end else if (hcnt_q == 4'd3) begin
					type_d = b_s1;
				end else if (hcnt_q == 4'd4) begin
					flags_d = b_s1;
				end else begin
					strm_d = {strm_q[22:0], b_s1};
				end
				hcnt_d = hcnt_q + 4'd1;
				if (hcnt_q == 4'(HEADER_LEN - 1)) begin
					hcnt_d = 4'd0;
					left_d = len_q;
					pad_d = '0;
					gcnt_d = '0;
					gsh_d = '0;
					fst_d = checks(type_q, flags_q, strm_d, len_q);
					emit_a = 1'b1;
					ra = mk(KIND_HEADER, type_q, flags_q, strm_d, len_q, 16'd0, 32'd0,
						1'b0, ST_OK);
					if (len_q == 24'd0) begin
						emit_b = 1'b1;
						rb = mk(KIND_END, type_q, flags_q, strm_d, len_q, 16'd0, 32'd0,
							1'b0, fst_d);
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_d = left_q - 24'd1;
				if (fst_q == ST_OK) begin
					if (type_q == T_SETTINGS) begin
						if (gcnt_q == 3'd5) begin
							emit_a = 1'b1;
							ra = mk(KIND_SETTING, type_q, flags_q, strm_q, len_q,
								sh[47:32], sh[31:0], 1'b0, ST_OK);
							gcnt_d = '0;
							gsh_d = '0;
						end else begin
							gcnt_d = gcnt_q + 3'd1;
							gsh_d = sh;
						end
					end else if (type_q == T_PRIORITY) begin
						gcnt_d = gcnt_q + 3'd1;
						gsh_d = sh;
						if (gcnt_q == 3'd4) begin
							emit_a = 1'b1;
							ra = mk(KIND_PRIORITY, type_q, flags_q, strm_q, len_q,
								{8'd0, sh[7:0]}, {1'b0, sh[38:8]}, sh[39], ST_OK);
						end
					end else if (type_q == T_HEADERS) begin
						if (flags_q[F_PADDED_BIT] && first) begin
							pad_d = b_s1;
							if ({16'd0, b_s1} > rest) begin
								fst_d = ST_PROTO;
							end else if (flags_q[F_PRIORITY_BIT] &&
								(rest - {16'd0, b_s1}) < 24'd5) begin
								fst_d = ST_SIZE;
							end
						end else if (flags_q[F_PRIORITY_BIT] && gcnt_q < 3'd5) begin
							gcnt_d = gcnt_q + 3'd1;
							gsh_d = sh;
							if (gcnt_q == 3'd4) begin
								emit_a = 1'b1;
								ra = mk(KIND_PRIORITY, type_q, flags_q, strm_q, len_q,
									{8'd0, sh[7:0]}, {1'b0, sh[38:8]}, sh[39], ST_OK);
							end
						end else if (left_q > {16'd0, pad_q}) begin
							emit_a = 1'b1;
							ra = mk(KIND_BLOCK, type_q, flags_q, strm_q, len_q,
								{8'd0, b_s1}, 32'd0, 1'b0, ST_OK);
						end
					end else if (type_q == T_CONTINUATION) begin
						emit_a = 1'b1;
						ra = mk(KIND_BLOCK, type_q, flags_q, strm_q, len_q,
							{8'd0, b_s1}, 32'd0, 1'b0, ST_OK);
					end
				end
				if (left_d == 24'd0) begin
					emit_b = 1'b1;
					rb = mk(KIND_END, type_q, flags_q, strm_q, len_q, 16'd0, 32'd0,
						1'b0, fst_d);
					phase_d = PH_HEADER;
					hcnt_d = 4'd0;
				end
			end
			default: begin
				phase_d = ph;
			end
		endcase
		push0 = v_s1 && (emit_a || emit_b);
		push1 = v_s1 && emit_a && emit_b;
		if (emit_a) begin
			r0 = ra;
			r1 = rb;
			r1.last = 1'b1;
			r0.last = !emit_b;
		end else begin
			r0 = rb;
			r0.last = 1'b1;
			r1 = rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pidx_q <= '0;
			hcnt_q <= '0;
			len_q <= '0;
			type_q <= '0;
			flags_q <= '0;
			strm_q <= '0;
			left_q <= '0;
			pad_q <= '0;
			gcnt_q <= '0;
			gsh_q <= '0;
			fst_q <= '0;
		end else if (v_s1) begin
			phase_q <= phase_d;
			pidx_q <= pidx_d;
			hcnt_q <= hcnt_d;
			len_q <= len_d;
			type_q <= type_d;
			flags_q <= flags_d;
			strm_q <= strm_d;
			left_q <= left_d;
			pad_q <= pad_d;
			gcnt_q <= gcnt_d;
			gsh_q <= gsh_d;
			fst_q <= fst_d;
		end
	end

	h2d_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.data0  (r0),
		.data1  (r1),
		.room   (room),
		.out    (out)
	);
endmodule

// ===== src/h2d_out_queue.sv =====
// Small result queue that holds up to two results from each byte plus slack.
module h2d_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  logic             push1,
	input  h2d_pkg::result_t data0,
	input  h2d_pkg::result_t data1,
	output logic             room,
	h2d_result_if.source     out
);
	import h2d_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] n_push;
	logic [3:0] fill;

	assign pop = out.valid && out.ready;
	assign n_push = {2'b0, push0} + {2'b0, push1};
	assign out.valid = cnt_q != 3'd0;
	assign out.data = mem_q[rd_q];
	// The byte taken now pushes up to two results in the next cycle, so the
	// count after this edge must leave two entries free.
	assign fill = {1'b0, cnt_q} + {1'b0, n_push} - {3'b0, pop};
	assign room = fill <= 4'd2;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= data0;
		end
		if (push1) begin
			mem_q[wr_q + {1'b0, push0}] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[1:0];
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + n_push - {2'b0, pop};
		end
	end
endmodule

// ===== src/h2d_checker.sv =====
// Port-level checker for the HTTP/2 deframer, bound to the top level.
module h2d_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input h2d_pkg::result_t out_data
);
	import h2d_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind <= KIND_END)
		else $error("result kind out of range");

	a_status_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_END |-> out_data.status == ST_OK)
		else $error("status set on a result that is not a frame end");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_END |-> out_data.last)
		else $error("frame end not marked last");
endmodule

bind http2_frame_deframer h2d_checker u_h2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_data  (out.data)
);
